### rtl/core/rasf_pkg.sv
// Shared constants, codes and controller/datapath command types for the Fenwick range core.
`default_nettype none

package rasf_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int TREE_TOP    = MAX_ENTRIES + 1;
  localparam int TREE_DEPTH  = MAX_ENTRIES + 2;
  localparam int ADDR_W      = $clog2(TREE_DEPTH);
  localparam int POS_W       = ADDR_W + 1;

  localparam int ACT_W = 2;
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int SUM_W = 64;
  localparam int CFG_W = 11;

  localparam logic [ACT_W-1:0] ACT_ADD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SET = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SUM = 2'd2;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);
  localparam logic [CFG_W-1:0] LIMIT_MAX = CFG_W'(MAX_ENTRIES);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_PRE,
    OP_MUL,
    OP_SAVE_HI,
    OP_SPAN,
    OP_DELTA,
    OP_ADD,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    SEL_LO,
    SEL_LO1,
    SEL_LO2,
    SEL_HI1,
    SEL_HI2
  } pos_sel_t;

  typedef enum logic {
    SRC_ACC,
    SRC_INC
  } mul_src_t;

  typedef struct packed {
    dp_op_t   op;
    pos_sel_t pos_sel;
    mul_src_t mul_src;
    logic     negate;
  } dp_cmd_t;

  typedef struct packed {
    logic             clear_done;
    logic             walk_done;
    logic             bad;
    logic [ACT_W-1:0] action;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/rasf_if.sv
// Valid/ready channel interfaces for request and response words.
`default_nettype none

interface rasf_req_if import rasf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic [IDX_W-1:0]        lo_index;
  logic [IDX_W-1:0]        hi_index;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, action, lo_index, hi_index, value, input ready);
  modport sink (input valid, action, lo_index, hi_index, value, output ready);
endinterface

interface rasf_rsp_if import rasf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] range_sum;
  logic                    bad_range;

  modport source (output valid, range_sum, bad_range, input ready);
  modport sink (input valid, range_sum, bad_range, output ready);
endinterface

`default_nettype wire

### rtl/core/rasf_datapath.sv
// Datapath: the two tree memories, the node walker, the multiplier and the result register.
`default_nettype none

module rasf_datapath import rasf_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire dp_cmd_t                 cmd,
  output dp_status_t                   status,
  input  wire logic [CFG_W-1:0]        entries,
  input  wire logic [ACT_W-1:0]        req_action,
  input  wire logic [IDX_W-1:0]        req_lo,
  input  wire logic [IDX_W-1:0]        req_hi,
  input  wire logic signed [VAL_W-1:0] req_value,
  output logic signed [SUM_W-1:0]      range_sum,
  output logic                         bad_range
);

  logic [SUM_W-1:0] slope_mem  [TREE_DEPTH];
  logic [SUM_W-1:0] offset_mem [TREE_DEPTH];

  logic [ACT_W-1:0]        act;
  logic [IDX_W-1:0]        lo;
  logic [IDX_W-1:0]        hi;
  logic signed [VAL_W-1:0] val;

  logic [ADDR_W-1:0] clr_addr;
  logic [POS_W-1:0]  pos;
  logic [ADDR_W-1:0] rd_addr;
  logic              walking;
  logic              rd_pend;
  logic              mode_add;

  logic [SUM_W-1:0] acc_s;
  logic [SUM_W-1:0] acc_o;
  logic [SUM_W-1:0] delta_s;
  logic [SUM_W-1:0] delta_o;
  logic [SUM_W-1:0] inc;
  logic [SUM_W-1:0] prod;
  logic [SUM_W-1:0] pre_hi;
  logic [SUM_W-1:0] span;
  logic [SUM_W-1:0] q_s;
  logic [SUM_W-1:0] q_o;

  logic [CFG_W-1:0] limit;
  logic [CFG_W-1:0] lo_cfg;
  logic [CFG_W-1:0] hi_cfg;
  logic             bad;
  logic [POS_W-1:0] lo_pos;
  logic [POS_W-1:0] hi_pos;
  logic [POS_W-1:0] sel_pos;
  logic [POS_W-1:0] lowbit;
  logic [POS_W-1:0] pos_next;
  logic             pos_ok;
  logic             issue;
  logic             is_clear;
  logic             we;
  logic [ADDR_W-1:0] wa;
  logic [SUM_W-1:0] wd_s;
  logic [SUM_W-1:0] wd_o;
  logic [SUM_W-1:0] mul_a;
  logic [SUM_W-1:0] val_ext;

  // Bounds check on the latched request.
  assign limit  = (entries > LIMIT_MAX) ? LIMIT_MAX : entries;
  assign lo_cfg = {{(CFG_W-IDX_W){1'b0}}, lo};
  assign hi_cfg = {{(CFG_W-IDX_W){1'b0}}, hi};

  always_comb begin
    case (act) inside
      ACT_ADD, ACT_SUM: bad = (lo > hi) || (hi_cfg >= limit);
      ACT_SET:          bad = (lo_cfg >= limit);
      default:          bad = 1'b1;
    endcase
  end

  assign lo_pos = {{(POS_W-IDX_W){1'b0}}, lo};
  assign hi_pos = {{(POS_W-IDX_W){1'b0}}, hi};

  always_comb begin
    case (cmd.pos_sel)
      SEL_LO:  sel_pos = lo_pos;
      SEL_LO1: sel_pos = lo_pos + POS_W'(1);
      SEL_LO2: sel_pos = lo_pos + POS_W'(2);
      SEL_HI1: sel_pos = hi_pos + POS_W'(1);
      SEL_HI2: sel_pos = hi_pos + POS_W'(2);
      default: sel_pos = lo_pos;
    endcase
  end

  // Update walks climb to the tree top; prefix walks descend to zero.
  assign lowbit   = pos & (~pos + POS_W'(1));
  assign pos_next = mode_add ? (pos + lowbit) : (pos - lowbit);
  assign pos_ok   = mode_add ? ((pos != '0) && (pos <= POS_W'(TREE_TOP))) : (pos != '0);
  assign issue    = walking && pos_ok;

  assign is_clear = (cmd.op == OP_CLEAR);
  assign we       = is_clear || (walking && rd_pend && mode_add);
  assign wa       = is_clear ? clr_addr : rd_addr;
  assign wd_s     = is_clear ? '0 : (q_s + delta_s);
  assign wd_o     = is_clear ? '0 : (q_o + delta_o);

  assign mul_a   = (cmd.mul_src == SRC_INC) ? inc : acc_s;
  assign val_ext = {{(SUM_W-VAL_W){val[VAL_W-1]}}, val};

  always_ff @(posedge clk) begin
    if (we) begin
      slope_mem[wa]  <= wd_s;
      offset_mem[wa] <= wd_o;
    end
    if (issue) begin
      q_s <= slope_mem[pos[ADDR_W-1:0]];
      q_o <= offset_mem[pos[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      walking  <= 1'b0;
      rd_pend  <= 1'b0;
    end else begin
      if (is_clear) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if ((cmd.op == OP_PRE) || (cmd.op == OP_ADD)) begin
        walking <= 1'b1;
      end else if (walking && !issue && !rd_pend) begin
        walking <= 1'b0;
      end
      rd_pend <= issue;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        act <= req_action;
        lo  <= req_lo;
        hi  <= req_hi;
        val <= req_value;
        inc <= {{(SUM_W-VAL_W){req_value[VAL_W-1]}}, req_value};
      end
      OP_PRE: begin
        pos      <= sel_pos;
        mode_add <= 1'b0;
        acc_s    <= '0;
        acc_o    <= '0;
      end
      OP_ADD: begin
        pos      <= sel_pos;
        mode_add <= 1'b1;
        delta_s  <= cmd.negate ? (~inc + SUM_W'(1)) : inc;
        delta_o  <= cmd.negate ? (~prod + SUM_W'(1)) : prod;
      end
      OP_MUL:     prod   <= mul_a * {{(SUM_W-POS_W){1'b0}}, sel_pos};
      OP_SAVE_HI: pre_hi <= prod - acc_o;
      OP_SPAN:    span   <= pre_hi - prod + acc_o;
      OP_DELTA:   inc    <= val_ext - span;
      OP_EMIT: begin
        range_sum <= ((act == ACT_SUM) && !bad) ? span : '0;
        bad_range <= bad;
      end
      default: ;
    endcase
    if (issue) begin
      pos     <= pos_next;
      rd_addr <= pos[ADDR_W-1:0];
    end
    if (rd_pend && !mode_add) begin
      acc_s <= acc_s + q_s;
      acc_o <= acc_o + q_o;
    end
  end

  assign status.clear_done = is_clear && (clr_addr == ADDR_W'(TREE_DEPTH - 1));
  assign status.walk_done  = walking && !issue && !rd_pend;
  assign status.bad        = bad;
  assign status.action     = act;

endmodule

`default_nettype wire

### rtl/core/rasf_ctrl.sv
// Controller: sequences the clearing pass and the tree walks of each request word.
`default_nettype none

module rasf_ctrl import rasf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output dp_cmd_t         cmd,
  input  wire dp_status_t status
);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_PRE_HI,
    S_PRE_HI_W,
    S_MUL_HI,
    S_SAVE_HI,
    S_PRE_LO,
    S_PRE_LO_W,
    S_MUL_LO,
    S_SPAN,
    S_DELTA,
    S_MUL_A,
    S_ADD_A,
    S_ADD_A_W,
    S_MUL_B,
    S_ADD_B,
    S_ADD_B_W,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   is_set;
  logic   can_emit;

  assign is_set   = (status.action == ACT_SET);
  assign can_emit = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    cmd.op      = OP_NONE;
    cmd.pos_sel = SEL_LO;
    cmd.mul_src = SRC_ACC;
    cmd.negate  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (status.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.bad) state_next = S_EMIT;
        else if (status.action == ACT_ADD) state_next = S_MUL_A;
        else state_next = S_PRE_HI;
      end
      S_PRE_HI: begin
        cmd.op      = OP_PRE;
        cmd.pos_sel = is_set ? SEL_LO1 : SEL_HI1;
        state_next  = S_PRE_HI_W;
      end
      S_PRE_HI_W: begin
        if (status.walk_done) state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.op      = OP_MUL;
        cmd.pos_sel = is_set ? SEL_LO1 : SEL_HI1;
        state_next  = S_SAVE_HI;
      end
      S_SAVE_HI: begin
        cmd.op     = OP_SAVE_HI;
        state_next = S_PRE_LO;
      end
      S_PRE_LO: begin
        cmd.op     = OP_PRE;
        state_next = S_PRE_LO_W;
      end
      S_PRE_LO_W: begin
        if (status.walk_done) state_next = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.op     = OP_MUL;
        state_next = S_SPAN;
      end
      S_SPAN: begin
        cmd.op     = OP_SPAN;
        state_next = is_set ? S_DELTA : S_EMIT;
      end
      S_DELTA: begin
        cmd.op     = OP_DELTA;
        state_next = S_MUL_A;
      end
      S_MUL_A: begin
        cmd.op      = OP_MUL;
        cmd.mul_src = SRC_INC;
        state_next  = S_ADD_A;
      end
      S_ADD_A: begin
        cmd.op      = OP_ADD;
        cmd.pos_sel = SEL_LO1;
        state_next  = S_ADD_A_W;
      end
      S_ADD_A_W: begin
        if (status.walk_done) state_next = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.op      = OP_MUL;
        cmd.mul_src = SRC_INC;
        cmd.pos_sel = is_set ? SEL_LO1 : SEL_HI1;
        state_next  = S_ADD_B;
      end
      S_ADD_B: begin
        cmd.op      = OP_ADD;
        cmd.pos_sel = is_set ? SEL_LO2 : SEL_HI2;
        cmd.negate  = 1'b1;
        state_next  = S_ADD_B_W;
      end
      S_ADD_B_W: begin
        if (status.walk_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (can_emit) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_EMIT) && can_emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/core/range_add_range_sum_fenwick_core.sv
// A tree walk visits at most 10 nodes on a prefix and 11 on an update, each fetched by a
// registered tree read; a rejected word skips the walks and goes straight to its response.
// Requests: one word at a time; the next word can be taken in the cycle after a response word
// is loaded, even while that word still waits for the sink.
// Reset: rst zeroes both trees in a clearing pass with no word taken; entries 1024.
`default_nettype none

module range_add_range_sum_fenwick_core import rasf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  rasf_req_if.sink              req,
  rasf_rsp_if.source            rsp
);

  // The single configuration register. It only bounds the indices; tree walks always span the
  // full tree, so stored sums stay consistent when it changes.
  logic [CFG_W-1:0] entries;

  dp_cmd_t    cmd;
  dp_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries <= CFG_RESET;
    end else if (cfg_we) begin
      entries <= cfg_wdata;
    end
  end

  // The controller walks through a fixed sequence per action. A range sum runs two prefix walks
  // over both trees at once and combines them as slope times position minus offset. A range add
  // runs two update walks that touch both trees. A point set reads the element first and then
  // adds the difference, so it runs all four walks.
  rasf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath latches the request word on acceptance and holds the response word in its
  // output register until the sink takes it.
  rasf_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .entries    (entries),
    .req_action (req.action),
    .req_lo     (req.lo_index),
    .req_hi     (req.hi_index),
    .req_value  (req.value),
    .range_sum  (rsp.range_sum),
    .bad_range  (rsp.bad_range)
  );

endmodule

`default_nettype wire
